### design/accel_ramp_generator_top_macros.svh
// ----------------------------------------------------------------------------
// accel_ramp_generator_top_macros.svh
// Assertion macros for the ramp generator; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ACCEL_RAMP_GENERATOR_TOP_MACROS_SVH
`define ACCEL_RAMP_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, clocked on clk, off during reset
`define ARG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ramp generator assertion failed");
// next-cycle implication, clocked on clk, off during reset
`define ARG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ramp generator assertion failed");
`else
`define ARG_ASSERT_IMP(lbl, ante, cons)
`define ARG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### design/argen_pkg.sv
// ----------------------------------------------------------------------------
// argen_pkg
// Word types, codes and the control store of the ramp generator.
// ----------------------------------------------------------------------------
package argen_pkg;

	// input word
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] elapsed;
	} in_word_t;

	// result word
	typedef struct packed {
		logic               running;
		logic signed [31:0] current_value;
		logic [16:0]        progress;
	} out_word_t;

	// actions
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_STOP  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_START_VALUE = 2'd0;
	localparam logic [1:0] REG_END_VALUE   = 2'd1;
	localparam logic [1:0] REG_INIT_VEL    = 2'd2;
	localparam logic [1:0] REG_ACCEL       = 2'd3;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// datapath operations
	localparam logic [3:0] OP_NOP        = 4'd0;
	localparam logic [3:0] OP_START      = 4'd1;
	localparam logic [3:0] OP_STOP       = 4'd2;
	localparam logic [3:0] OP_MUL_LD_ACC = 4'd3;
	localparam logic [3:0] OP_MUL_LD_VEL = 4'd4;
	localparam logic [3:0] OP_MUL_STEP   = 4'd5;
	localparam logic [3:0] OP_VEL_UPD    = 4'd6;
	localparam logic [3:0] OP_POS_UPD    = 4'd7;
	localparam logic [3:0] OP_DIV_LOAD   = 4'd8;
	localparam logic [3:0] OP_DIV_STEP   = 4'd9;
	localparam logic [3:0] OP_DIV_DONE   = 4'd10;
	localparam logic [3:0] OP_PROG_FULL  = 4'd11;
	localparam logic [3:0] OP_REPORT     = 4'd12;

	// jump conditions
	localparam logic [2:0] C_NEVER    = 3'd0;
	localparam logic [2:0] C_ALWAYS   = 3'd1;
	localparam logic [2:0] C_LOOP     = 3'd2;
	localparam logic [2:0] C_DISARMED = 3'd3;
	localparam logic [2:0] C_GE       = 3'd4;

	// program addresses
	localparam logic [3:0] A_START    = 4'd0;
	localparam logic [3:0] A_STOP     = 4'd1;
	localparam logic [3:0] A_TICK     = 4'd2;
	localparam logic [3:0] A_MUL_ACC  = 4'd3;
	localparam logic [3:0] A_LOOP_ACC = 4'd4;
	localparam logic [3:0] A_VEL      = 4'd5;
	localparam logic [3:0] A_MUL_VEL  = 4'd6;
	localparam logic [3:0] A_LOOP_VEL = 4'd7;
	localparam logic [3:0] A_POS      = 4'd8;
	localparam logic [3:0] A_PROG     = 4'd9;
	localparam logic [3:0] A_LOOP_DIV = 4'd10;
	localparam logic [3:0] A_DIV_DONE = 4'd11;
	localparam logic [3:0] A_FULL     = 4'd12;
	localparam logic [3:0] A_REPORT   = 4'd13;

	// one control word
	typedef struct packed {
		logic [3:0] op;
		logic [2:0] cond;
		logic [3:0] target;
	} ucode_t;

	// control store
	function automatic ucode_t ucode_rom(input logic [3:0] addr);
		ucode_t w;
		w = '{op: OP_NOP, cond: C_NEVER, target: A_REPORT};
		unique case (addr)
			A_START:    w = '{op: OP_START,      cond: C_ALWAYS,   target: A_PROG};
			A_STOP:     w = '{op: OP_STOP,       cond: C_ALWAYS,   target: A_REPORT};
			A_TICK:     w = '{op: OP_NOP,        cond: C_DISARMED, target: A_REPORT};
			A_MUL_ACC:  w = '{op: OP_MUL_LD_ACC, cond: C_NEVER,    target: A_REPORT};
			A_LOOP_ACC: w = '{op: OP_MUL_STEP,   cond: C_LOOP,     target: A_LOOP_ACC};
			A_VEL:      w = '{op: OP_VEL_UPD,    cond: C_NEVER,    target: A_REPORT};
			A_MUL_VEL:  w = '{op: OP_MUL_LD_VEL, cond: C_NEVER,    target: A_REPORT};
			A_LOOP_VEL: w = '{op: OP_MUL_STEP,   cond: C_LOOP,     target: A_LOOP_VEL};
			A_POS:      w = '{op: OP_POS_UPD,    cond: C_NEVER,    target: A_REPORT};
			A_PROG:     w = '{op: OP_DIV_LOAD,   cond: C_GE,       target: A_FULL};
			A_LOOP_DIV: w = '{op: OP_DIV_STEP,   cond: C_LOOP,     target: A_LOOP_DIV};
			A_DIV_DONE: w = '{op: OP_DIV_DONE,   cond: C_ALWAYS,   target: A_REPORT};
			A_FULL:     w = '{op: OP_PROG_FULL,  cond: C_NEVER,    target: A_REPORT};
			A_REPORT:   w = '{op: OP_REPORT,     cond: C_NEVER,    target: A_REPORT};
			default:    w = '{op: OP_REPORT,     cond: C_NEVER,    target: A_REPORT};
		endcase
		return w;
	endfunction

	// saturate a widened sum to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
			r = v[31:0];
		end else if (v[34]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7fff_ffff;
		end
		return r;
	endfunction

	// |a - b| of two signed 32-bit values
	function automatic logic [31:0] absdiff(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic [32:0] d;
		logic [32:0] n;
		d = {a[31], a} - {b[31], b};
		n = -d;
		return d[32] ? n[31:0] : d[31:0];
	endfunction

endpackage

### design/accel_ramp_generator_top.sv
// ----------------------------------------------------------------------------
// accel_ramp_generator_top
// Constant-acceleration ramp generator run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// One input word is taken at a time and gives one result word. An unused
// action code goes straight to the report step. The work is done by the
// shared datapath: a 16-step shift-add multiplier used twice (velocity, then
// displacement) and a 16-step restoring divider for the progress. A start
// or tick whose distance already covers the span skips the divider. The input
// is ready again as soon as a result is loaded. A finished result waits in
// an output register, and the next word is taken while it waits; that word
// stalls at its report step until the held result is taken. Configuration
// registers may be written at any time the block is idle and take effect at
// the next start word.
`include "accel_ramp_generator_top_macros.svh"

module accel_ramp_generator_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  argen_pkg::in_word_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output argen_pkg::out_word_t  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);
	import argen_pkg::*;

	// configuration and latched ramp settings
	logic signed [31:0] start_value_q, end_value_q, init_vel_q, accel_q;
	logic signed [31:0] lat_start_q, lat_end_q, lat_accel_q;

	// ramp state
	logic signed [31:0] value_q, vel_q;
	logic               armed_q;
	logic [16:0]        progress_q;

	// sequencer
	logic       busy_q;
	logic [3:0] pc_q;
	logic [3:0] cnt_q;
	logic [15:0] dt_q;
	ucode_t     uw;
	logic       step_en;
	logic       take_jump;

	// multiplier and divider registers
	logic [31:0] mul_mag_q;
	logic        mul_neg_q;
	logic [31:0] mul_hi_q;
	logic [15:0] mul_lo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [15:0] quot_q;

	// output register
	logic      out_valid_q;
	out_word_t out_q;

	// combinational datapath
	logic [32:0]        mul_sum;
	logic [32:0]        mul_round;
	logic signed [33:0] mterm;
	logic signed [34:0] vel_sum;
	logic signed [34:0] pos_sum;
	logic signed [31:0] pos_sat;
	logic               up;
	logic               clamp;
	logic [31:0]        num_now;
	logic [31:0]        den_now;
	logic               span_done;
	logic [32:0]        div_sh;
	logic [32:0]        div_diff;
	logic               div_bit;
	logic [31:0]        acc_mag;
	logic [31:0]        vel_mag;
	logic [3:0]         entry_pc;

	assign in_ready  = !busy_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// fetch and stall at report while the output register is full
	assign uw      = ucode_rom(pc_q);
	assign step_en = busy_q && !(uw.op == OP_REPORT && out_valid_q && !out_ready);

	// jump condition
	always_comb begin
		take_jump = 1'b0;
		unique case (uw.cond)
			C_NEVER:    take_jump = 1'b0;
			C_ALWAYS:   take_jump = 1'b1;
			C_LOOP:     take_jump = (cnt_q != 4'd0);
			C_DISARMED: take_jump = !armed_q;
			C_GE:       take_jump = span_done;
			default:    take_jump = 1'b0;
		endcase
	end

	// entry point by action
	always_comb begin
		unique case (in_data.action)
			ACT_TICK:  entry_pc = A_TICK;
			ACT_START: entry_pc = A_START;
			ACT_STOP:  entry_pc = A_STOP;
			default:   entry_pc = A_REPORT;
		endcase
	end

	// shift-add multiplier step and rounding of the Q16.16 product
	assign mul_sum   = {1'b0, mul_hi_q} + (mul_lo_q[0] ? {1'b0, mul_mag_q} : 33'd0);
	assign mul_round = {1'b0, mul_hi_q} + {32'd0, mul_lo_q[15]};
	assign mterm     = mul_neg_q ? -$signed({1'b0, mul_round}) : $signed({1'b0, mul_round});

	// operand magnitudes
	assign acc_mag = lat_accel_q[31] ? (~lat_accel_q + 32'd1) : lat_accel_q;
	assign vel_mag = vel_q[31] ? (~vel_q + 32'd1) : vel_q;

	// velocity and position sums
	assign vel_sum = {{3{vel_q[31]}}, vel_q} + {mterm[33], mterm};
	assign up      = lat_end_q >= lat_start_q;
	assign pos_sum = up ? ({{3{value_q[31]}}, value_q} + {mterm[33], mterm})
	                    : ({{3{value_q[31]}}, value_q} - {mterm[33], mterm});
	assign pos_sat = sat32(pos_sum);
	assign clamp   = up ? (pos_sat >= lat_end_q) : (pos_sat <= lat_end_q);

	// progress operands; a covered span saturates without dividing
	assign num_now   = absdiff(lat_start_q, value_q);
	assign den_now   = absdiff(lat_start_q, lat_end_q);
	assign span_done = num_now >= den_now;

	// restoring divider step
	assign div_sh   = {rem_q, 1'b0};
	assign div_diff = div_sh - {1'b0, den_q};
	assign div_bit  = div_sh >= {1'b0, den_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_value_q <= '0;
			end_value_q   <= '0;
			init_vel_q    <= '0;
			accel_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_VALUE: start_value_q <= cfg_data;
				REG_END_VALUE:   end_value_q   <= cfg_data;
				REG_INIT_VEL:    init_vel_q    <= cfg_data;
				REG_ACCEL:       accel_q       <= cfg_data;
				default:         start_value_q <= start_value_q;
			endcase
		end
	end

	// sequencer: program counter, loop counter, busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= A_REPORT;
			cnt_q  <= '0;
			dt_q   <= '0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				pc_q   <= entry_pc;
				dt_q   <= in_data.elapsed;
			end
		end else if (step_en) begin
			if (uw.op == OP_REPORT) begin
				busy_q <= 1'b0;
			end
			pc_q <= take_jump ? uw.target : pc_q + 4'd1;
			if (uw.op == OP_MUL_LD_ACC || uw.op == OP_MUL_LD_VEL || uw.op == OP_DIV_LOAD) begin
				cnt_q <= 4'd15;
			end else if (uw.op == OP_MUL_STEP || uw.op == OP_DIV_STEP) begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	// ramp state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_start_q <= '0;
			lat_end_q   <= '0;
			lat_accel_q <= '0;
			value_q     <= '0;
			vel_q       <= '0;
			armed_q     <= 1'b0;
			progress_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise on the report step, drop once the word is taken
			if (step_en && uw.op == OP_REPORT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (step_en) begin
				unique case (uw.op)
					OP_START: begin
						lat_start_q <= start_value_q;
						lat_end_q   <= end_value_q;
						lat_accel_q <= accel_q;
						value_q     <= start_value_q;
						vel_q       <= init_vel_q;
						armed_q     <= 1'b1;
					end
					OP_STOP: begin
						armed_q <= 1'b0;
					end
					OP_VEL_UPD: begin
						vel_q <= sat32(vel_sum);
					end
					OP_POS_UPD: begin
						if (clamp) begin
							value_q <= lat_end_q;
							armed_q <= 1'b0;
						end else begin
							value_q <= pos_sat;
						end
					end
					OP_DIV_DONE: begin
						progress_q <= {1'b0, quot_q};
					end
					OP_PROG_FULL: begin
						progress_q <= ONE_Q16;
					end
					default: begin
						armed_q <= armed_q;
					end
				endcase
			end
		end
	end

	// multiplier and divider datapath
	always_ff @(posedge clk) begin
		if (step_en) begin
			case (uw.op)
				OP_MUL_LD_ACC: begin
					mul_mag_q <= acc_mag;
					mul_neg_q <= lat_accel_q[31];
					mul_hi_q  <= '0;
					mul_lo_q  <= dt_q;
				end
				OP_MUL_LD_VEL: begin
					mul_mag_q <= vel_mag;
					mul_neg_q <= vel_q[31];
					mul_hi_q  <= '0;
					mul_lo_q  <= dt_q;
				end
				OP_MUL_STEP: begin
					mul_hi_q <= mul_sum[32:1];
					mul_lo_q <= {mul_sum[0], mul_lo_q[15:1]};
				end
				OP_DIV_LOAD: begin
					rem_q  <= num_now;
					den_q  <= den_now;
					quot_q <= '0;
				end
				OP_DIV_STEP: begin
					rem_q  <= div_bit ? div_diff[31:0] : div_sh[31:0];
					quot_q <= {quot_q[14:0], div_bit};
				end
				default: begin
					mul_neg_q <= mul_neg_q;
				end
			endcase
		end
	end

	// result register load
	always_ff @(posedge clk) begin
		if (step_en && uw.op == OP_REPORT) begin
			out_q.running       <= armed_q;
			out_q.current_value <= value_q;
			out_q.progress      <= progress_q;
		end
	end

	// checks
	`ARG_ASSERT_IMP(a_result_from_report, $rose(out_valid_q), $past(pc_q) == A_REPORT)
	`ARG_ASSERT_IMP(a_done_leaves_result, $fell(busy_q), out_valid_q)
	`ARG_ASSERT_IMP(a_progress_bound, out_valid_q, out_q.progress <= ONE_Q16)
	`ARG_ASSERT_NXT(a_accept_starts, in_valid && in_ready, busy_q)

endmodule
